FILE: rtl/button_click_hold_detector_unit_assert.svh
// assertion macros shared by the button detector rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef BUTTON_CLICK_HOLD_DETECTOR_UNIT_ASSERT_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bcd_pkg.sv
// types and constants for the button click / hold detector
// no dependencies
package bcd_pkg;

    localparam int CfgIdxW = 8;
    localparam int CfgW    = 16;
    localparam int TimeW   = 32;
    localparam int EvW     = 4;

    // register indexes
    localparam logic [CfgIdxW-1:0] CfgDebounce = 8'd0;
    localparam logic [CfgIdxW-1:0] CfgGap      = 8'd1;
    localparam logic [CfgIdxW-1:0] CfgHold     = 8'd2;
    localparam logic [CfgIdxW-1:0] CfgLongHold = 8'd3;

    localparam logic [CfgW-1:0] DebounceRst = 16'd20;
    localparam logic [CfgW-1:0] GapRst      = 16'd250;
    localparam logic [CfgW-1:0] HoldRst     = 16'd1000;
    localparam logic [CfgW-1:0] LongHoldRst = 16'd3000;

    // bit positions in the event flag vector
    localparam int EvClick  = 0;
    localparam int EvDouble = 1;
    localparam int EvHold   = 2;
    localparam int EvLong   = 3;

    typedef struct packed {
        logic [CfgW-1:0] debounce_ms;
        logic [CfgW-1:0] double_click_gap_ms;
        logic [CfgW-1:0] hold_ms;
        logic [CfgW-1:0] long_hold_ms;
    } cfg_t;

    typedef struct packed {
        logic             level;
        logic [TimeW-1:0] now_ms;
        logic [EvW-1:0]   clear_events;
    } in_item_t;

    typedef struct packed {
        logic click_flag;
        logic double_click_flag;
        logic hold_flag;
        logic long_hold_flag;
    } out_item_t;

endpackage

FILE: rtl/bcd_cfg.sv
// configuration registers of the button detector
// depends on bcd_pkg
module bcd_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [bcd_pkg::CfgIdxW-1:0] wr_index,
    input  logic [bcd_pkg::CfgW-1:0]    wr_data,
    output bcd_pkg::cfg_t               cfg
);

    bcd_pkg::cfg_t cfg_reg;
    bcd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                bcd_pkg::CfgDebounce: cfg_next.debounce_ms         = wr_data;
                bcd_pkg::CfgGap:      cfg_next.double_click_gap_ms = wr_data;
                bcd_pkg::CfgHold:     cfg_next.hold_ms             = wr_data;
                bcd_pkg::CfgLongHold: cfg_next.long_hold_ms        = wr_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms         <= bcd_pkg::DebounceRst;
            cfg_reg.double_click_gap_ms <= bcd_pkg::GapRst;
            cfg_reg.hold_ms             <= bcd_pkg::HoldRst;
            cfg_reg.long_hold_ms        <= bcd_pkg::LongHoldRst;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/bcd_step.sv
// per-sample detector state and its update
// depends on bcd_pkg and the assertion macro header
`include "button_click_hold_detector_unit_assert.svh"

module bcd_step (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  bcd_pkg::in_item_t       item,
    input  bcd_pkg::cfg_t           cfg,
    output logic [bcd_pkg::EvW-1:0] flags
);

    logic                      last_level_reg, last_level_next;
    logic [bcd_pkg::TimeW-1:0] press_time_reg, press_time_next;
    logic [bcd_pkg::TimeW-1:0] release_time_reg, release_time_next;
    logic                      ignore_release_reg, ignore_release_next;
    logic                      single_allowed_reg, single_allowed_next;
    logic                      hold_done_reg, hold_done_next;
    logic                      long_done_reg, long_done_next;
    logic                      dbl_on_rel_reg, dbl_on_rel_next;
    logic                      await_dbl_reg, await_dbl_next;
    logic [bcd_pkg::EvW-1:0]   flags_reg, flags_next;

    logic [bcd_pkg::TimeW-1:0] since_rel, since_press;
    logic [bcd_pkg::TimeW-1:0] since_rel2, since_press2;
    logic [bcd_pkg::TimeW-1:0] deb_x, gap_x, hold_x, long_x;
    logic                      press_hit, rel_hit, rel_taken;

    assign deb_x  = {16'd0, cfg.debounce_ms};
    assign gap_x  = {16'd0, cfg.double_click_gap_ms};
    assign hold_x = {16'd0, cfg.hold_ms};
    assign long_x = {16'd0, cfg.long_hold_ms};

    assign since_rel   = item.now_ms - release_time_reg;
    assign since_press = item.now_ms - press_time_reg;

    assign press_hit = !item.level && last_level_reg && (since_rel > deb_x);
    assign rel_hit   = !press_hit && item.level && !last_level_reg && (since_press > deb_x);
    assign rel_taken = rel_hit && !ignore_release_reg;

    // elapsed times after the edge update: a fresh stamp reads as zero
    assign since_rel2   = rel_taken ? '0 : since_rel;
    assign since_press2 = press_hit ? '0 : since_press;

    always_comb
    begin
        last_level_next     = item.level;
        press_time_next     = press_time_reg;
        release_time_next   = release_time_reg;
        ignore_release_next = ignore_release_reg;
        single_allowed_next = single_allowed_reg;
        hold_done_next      = hold_done_reg;
        long_done_next      = long_done_reg;
        dbl_on_rel_next     = dbl_on_rel_reg;
        await_dbl_next      = await_dbl_reg;
        flags_next          = flags_reg & ~item.clear_events;

        if (press_hit)
        begin
            press_time_next     = item.now_ms;
            ignore_release_next = 1'b0;
            single_allowed_next = 1'b1;
            hold_done_next      = 1'b0;
            long_done_next      = 1'b0;
            dbl_on_rel_next     = (since_rel < gap_x) && !dbl_on_rel_reg && await_dbl_reg;
            await_dbl_next      = 1'b0;
        end
        else if (rel_taken)
        begin
            release_time_next = item.now_ms;
            if (!dbl_on_rel_reg)
            begin
                await_dbl_next = 1'b1;
            end
            else
            begin
                flags_next[bcd_pkg::EvDouble] = 1'b1;
                dbl_on_rel_next               = 1'b0;
                await_dbl_next                = 1'b0;
                single_allowed_next           = 1'b0;
            end
        end

        // gap expired with no second press
        if (item.level && (since_rel2 >= gap_x) && await_dbl_next && !dbl_on_rel_next
            && single_allowed_next)
        begin
            flags_next[bcd_pkg::EvClick] = 1'b1;
            await_dbl_next               = 1'b0;
        end

        if (!item.level && (since_press2 >= hold_x))
        begin
            if (!hold_done_next)
            begin
                flags_next[bcd_pkg::EvHold] = 1'b1;
                ignore_release_next         = 1'b1;
                dbl_on_rel_next             = 1'b0;
                await_dbl_next              = 1'b0;
                hold_done_next              = 1'b1;
            end
            if ((since_press2 >= long_x) && !long_done_next)
            begin
                flags_next[bcd_pkg::EvLong] = 1'b1;
                long_done_next              = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg     <= 1'b1;
            press_time_reg     <= '0;
            release_time_reg   <= '0;
            ignore_release_reg <= 1'b0;
            single_allowed_reg <= 1'b1;
            hold_done_reg      <= 1'b0;
            long_done_reg      <= 1'b0;
            dbl_on_rel_reg     <= 1'b0;
            await_dbl_reg      <= 1'b0;
            flags_reg          <= '0;
        end
        else if (advance)
        begin
            last_level_reg     <= last_level_next;
            press_time_reg     <= press_time_next;
            release_time_reg   <= release_time_next;
            ignore_release_reg <= ignore_release_next;
            single_allowed_reg <= single_allowed_next;
            hold_done_reg      <= hold_done_next;
            long_done_reg      <= long_done_next;
            dbl_on_rel_reg     <= dbl_on_rel_next;
            await_dbl_reg      <= await_dbl_next;
            flags_reg          <= flags_next;
        end
    end

    assign flags = flags_next;

    // long hold is only reached through hold, and a press clears both together
    `BCD_ASSERT_NOW(a_long_needs_hold, long_done_reg, hold_done_reg,
        "long hold done without hold done")
    // releases are ignored only after a hold
    `BCD_ASSERT_NOW(a_ignore_needs_hold, ignore_release_reg, hold_done_reg,
        "release ignored without a hold")
    // flags are sticky unless the request clears them
    `BCD_ASSERT_NEXT(a_flags_sticky, advance && (item.clear_events == '0),
        (flags_reg & $past(flags_reg)) == $past(flags_reg),
        "event flag dropped without a clear")

endmodule

FILE: rtl/button_click_hold_detector_unit.sv
// top level of the button click / double click / hold detector
// depends on bcd_pkg, bcd_cfg, bcd_step and the assertion macro header
//
// usage:
//   in channel (in_valid / in_stall / in_data): one request per sample of the
//   button line, carrying level, now_ms and a mask of flags to clear first.
//   out channel (out_valid / out_stall / out_data): one result per request,
//   the four sticky event flags after that sample, in request order.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes one of
//   the four 16-bit timing registers; cfg_ready is always high and indexes
//   above 3 are dropped. write only while no request is in flight.
//   flow: a request lands in an input register; once the result register is
//   free, the detector state updates and the flags land in the result
//   register, where the result is offered until out_stall lets it leave.
//   one request per cycle sustained while out_stall stays low.
//   stall: while out_stall holds a pending result, one more request is taken
//   into the input register, then in_stall rises until the result drains.
//   reset: registers return to 20 / 250 / 1000 / 3000 ms, the line reads as
//   released, all flags clear and both channels are empty.
`include "button_click_hold_detector_unit_assert.svh"

module button_click_hold_detector_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  bcd_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output bcd_pkg::out_item_t          out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bcd_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [bcd_pkg::CfgW-1:0]    cfg_data
);

    bcd_pkg::cfg_t           cfg;
    bcd_pkg::in_item_t       in_data_reg;
    logic                    in_valid_reg, in_valid_next;
    bcd_pkg::out_item_t      out_data_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [bcd_pkg::EvW-1:0] flags;
    logic                    advance;
    logic                    in_take;

    assign cfg_ready = 1'b1;

    bcd_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // the held request moves on whenever the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    bcd_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .flags   (flags)
    );

    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg.click_flag        <= flags[bcd_pkg::EvClick];
            out_data_reg.double_click_flag <= flags[bcd_pkg::EvDouble];
            out_data_reg.hold_flag         <= flags[bcd_pkg::EvHold];
            out_data_reg.long_hold_flag    <= flags[bcd_pkg::EvLong];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // every processed request leaves a result behind
    `BCD_ASSERT_NEXT(a_advance_gives_result, advance, out_valid_reg,
        "processed request produced no result")
    // a taken request is held in the input register
    `BCD_ASSERT_NEXT(a_take_fills_input, in_take, in_valid_reg,
        "taken request not held")
    // a held request that cannot move stays put
    `BCD_ASSERT_NEXT(a_held_not_lost, in_valid_reg && !advance,
        in_valid_reg && $stable(in_data_reg),
        "held request lost or changed")

endmodule

FILE: test/button_click_hold_detector_unit_tb.sv
// self-checking testbench for button_click_hold_detector_unit: directed and random button
// gestures with random idling on both channels, checked against an in-bench flag predictor
// depends on bcd_pkg and the button_click_hold_detector_unit rtl
`timescale 1ns / 1ps

module button_click_hold_detector_unit_tb;

    import bcd_pkg::*;

    localparam int CycleLimit = 600000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    in_item_t            in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    out_item_t           out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgW-1:0]     cfg_data = '0;

    // predictor copy of the timing registers
    logic [CfgW-1:0]     debounce_lim;
    logic [CfgW-1:0]     gap_lim;
    logic [CfgW-1:0]     hold_lim;
    logic [CfgW-1:0]     long_lim;

    // predictor copy of the detector state
    logic                line_was_high;
    logic [TimeW-1:0]    pressed_at;
    logic [TimeW-1:0]    released_at;
    logic                skip_release;
    logic                click_armed;
    logic                hold_raised;
    logic                long_raised;
    logic                double_armed;
    logic                gap_open;
    logic [EvW-1:0]      flags;

    out_item_t           expected_flags[$];
    int                  mismatches = 0;
    int                  samples_sent = 0;
    int                  cycle_count = 0;
    int                  holdoff_req = 0;
    logic                burst_mode = 1'b0;
    logic [TimeW-1:0]    line_ms = '0;
    logic                line_level = 1'b1;

    string               flag_names[EvW] = '{"long_hold_flag", "hold_flag",
                                             "double_click_flag", "click_flag"};

    button_click_hold_detector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("button_click_hold_detector_unit verification failed");
            $finish;
        end
    end

    // advances the detector state by one sample and returns the flags after it
    function automatic out_item_t detect_sample(in_item_t s);
        logic [TimeW-1:0] since_rel;
        logic [TimeW-1:0] since_prs;
        out_item_t        r;
        flags = flags & ~s.clear_events;
        since_rel = s.now_ms - released_at;
        since_prs = s.now_ms - pressed_at;
        if (!s.level && line_was_high && since_rel > debounce_lim)
        begin
            pressed_at = s.now_ms;
            skip_release = 1'b0;
            click_armed = 1'b1;
            hold_raised = 1'b0;
            long_raised = 1'b0;
            double_armed = (since_rel < gap_lim) && !double_armed && gap_open;
            gap_open = 1'b0;
        end
        else if (s.level && !line_was_high && since_prs > debounce_lim)
        begin
            if (!skip_release)
            begin
                released_at = s.now_ms;
                if (!double_armed)
                    gap_open = 1'b1;
                else
                begin
                    flags[EvDouble] = 1'b1;
                    double_armed = 1'b0;
                    gap_open = 1'b0;
                    click_armed = 1'b0;
                end
            end
        end
        since_rel = s.now_ms - released_at;
        since_prs = s.now_ms - pressed_at;
        if (s.level && since_rel >= gap_lim && gap_open && !double_armed && click_armed)
        begin
            flags[EvClick] = 1'b1;
            gap_open = 1'b0;
        end
        if (!s.level && since_prs >= hold_lim)
        begin
            if (!hold_raised)
            begin
                flags[EvHold] = 1'b1;
                skip_release = 1'b1;
                double_armed = 1'b0;
                gap_open = 1'b0;
                hold_raised = 1'b1;
            end
            // long hold is only looked at once the hold threshold is passed
            if (since_prs >= long_lim && !long_raised)
            begin
                flags[EvLong] = 1'b1;
                long_raised = 1'b1;
            end
        end
        line_was_high = s.level;
        r.click_flag        = flags[EvClick];
        r.double_click_flag = flags[EvDouble];
        r.hold_flag         = flags[EvHold];
        r.long_hold_flag    = flags[EvLong];
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_flags.size() == 0)
            begin
                $display("%0t ns: result with none expected, actual %b", $time, out_data);
                mismatches++;
            end
            else
            begin
                want = expected_flags.pop_front();
                for (int i = 0; i < EvW; i++)
                begin
                    if (out_data[i] !== want[i])
                    begin
                        $display("%0t ns: %s expected %b actual %b",
                                 $time, flag_names[i], want[i], out_data[i]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // output stall: random phases, plus a long hold-off on request
    always @(posedge clk)
    begin
        int holdoff_left;
        int stall_run;
        int phase_left;
        int mode;
        if (holdoff_req > 0)
        begin
            holdoff_left = holdoff_req;
            holdoff_req = 0;
        end
        if (phase_left <= 0)
        begin
            mode = $urandom_range(0, 2);
            phase_left = $urandom_range(50, 400);
        end
        phase_left--;
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            out_stall <= 1'b1;
        end
        else if (stall_run > 0)
        begin
            stall_run--;
            out_stall <= 1'b1;
        end
        else if (mode != 0 && $urandom_range(0, 99) < (mode == 1 ? 10 : 35))
        begin
            stall_run = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    function automatic int next_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [EvW-1:0] pick_clear();
        return ($urandom_range(0, 5) == 0) ? EvW'($urandom_range(0, 15)) : '0;
    endfunction

    // a delay around a threshold, half the time right at the edges of it
    function automatic logic [TimeW-1:0] near(logic [CfgW-1:0] thr);
        logic [TimeW-1:0] t;
        t = TimeW'(thr);
        case ($urandom_range(0, 5))
            0:       return (t == 0) ? t : t - 1;
            1:       return t;
            2:       return t + 1;
            3:       return $urandom_range(0, t + t + 2);
            4:       return $urandom_range(0, 3);
            default: return t + $urandom_range(2, 50);
        endcase
    endfunction

    task automatic send_sample(input in_item_t s, input int gap);
        in_valid <= 1'b1;
        in_data  <= s;
        do
            @(posedge clk);
        while (in_stall);
        expected_flags.push_back(detect_sample(s));
        samples_sent++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic step_at(input logic level, input logic [TimeW-1:0] now,
                           input logic [EvW-1:0] clr);
        in_item_t s;
        s.level        = level;
        s.now_ms       = now;
        s.clear_events = clr;
        line_ms    = now;
        line_level = level;
        send_sample(s, next_gap());
    endtask

    task automatic step_line(input logic level, input logic [TimeW-1:0] dt);
        step_at(level, line_ms + dt, pick_clear());
    endtask

    // wait for every outstanding result, then let the pipeline go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_flags.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CfgDebounce: debounce_lim = val;
            CfgGap:      gap_lim = val;
            CfgHold:     hold_lim = val;
            CfgLongHold: long_lim = val;
            default:     ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_timing(input logic [CfgW-1:0] deb, input logic [CfgW-1:0] gap,
                                input logic [CfgW-1:0] hold, input logic [CfgW-1:0] lng);
        settle();
        write_reg(CfgDebounce, deb);
        write_reg(CfgGap, gap);
        write_reg(CfgHold, hold);
        write_reg(CfgLongHold, lng);
        // out-of-range index, must leave every register alone
        write_reg(CfgIdxW'($urandom_range(4, 255)), CfgW'($urandom));
    endtask

    // one button gesture with random timing around the current thresholds
    task automatic play_gesture();
        int kind;
        int reps;
        if ($urandom_range(0, 15) == 0)
            burst_mode = !burst_mode;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2:
            begin
                step_line(1'b0, near(debounce_lim));
                reps = $urandom_range(0, 2);
                repeat (reps) step_line(1'b0, $urandom_range(0, hold_lim / 2));
                step_line(1'b1, near(debounce_lim));
                reps = $urandom_range(1, 3);
                repeat (reps) step_line(1'b1, near(gap_lim));
            end
            3, 4:
            begin
                step_line(1'b0, near(debounce_lim));
                step_line(1'b1, near(debounce_lim));
                step_line(1'b0, near(gap_lim));
                step_line(1'b1, near(debounce_lim));
                step_line(1'b1, near(gap_lim));
            end
            5, 6:
            begin
                step_line(1'b0, near(debounce_lim));
                reps = $urandom_range(1, 4);
                repeat (reps)
                    step_line(1'b0, $urandom_range(0, 1) ? near(hold_lim) : near(long_lim) >> 1);
                step_line(1'b1, near(debounce_lim));
                step_line(1'b1, near(gap_lim));
            end
            7:
            begin
                // contact bounce around the debounce window
                reps = $urandom_range(2, 6);
                repeat (reps) step_line(!line_level, near(debounce_lim));
            end
            8:
                step_at(1'($urandom_range(0, 1)), $urandom, EvW'($urandom_range(0, 15)));
            default:
                step_line(1'b1, $urandom);
        endcase
    endtask

    task automatic run_gestures(input int count);
        int stop_at;
        stop_at = samples_sent + count;
        while (samples_sent < stop_at)
            play_gesture();
        burst_mode = 1'b0;
    endtask

    task automatic test_power_up();
        step_at(1'b1, 32'd0, 4'b0000);
        // press inside the debounce window from reset, hold still measures from time 0
        step_at(1'b0, 32'd5, 4'b0000);
        step_at(1'b0, 32'd1000, 4'b0000);
        step_at(1'b0, 32'd3000, 4'b0000);
        // release after hold is ignored, clear everything in the same step
        step_at(1'b1, 32'd3100, 4'b1111);
    endtask

    task automatic test_directed_gestures();
        // single click once the gap expires
        step_at(1'b0, 32'd10000, 4'b0000);
        step_at(1'b1, 32'd10100, 4'b0000);
        step_at(1'b1, 32'd10350, 4'b0000);
        // double click
        step_at(1'b0, 32'd20000, 4'b0001);
        step_at(1'b1, 32'd20100, 4'b0000);
        step_at(1'b0, 32'd20200, 4'b0000);
        step_at(1'b1, 32'd20300, 4'b0000);
        step_at(1'b1, 32'd21000, 4'b0000);
        // hold raised in the same step that clears it, then long hold
        step_at(1'b0, 32'd40000, 4'b0010);
        step_at(1'b0, 32'd41000, 4'b0100);
        step_at(1'b0, 32'd43000, 4'b1000);
        step_at(1'b1, 32'd43100, 4'b1111);
        // click across the 32-bit wrap
        step_at(1'b0, 32'hFFFF_FF00, 4'b0000);
        step_at(1'b1, 32'h0000_0050, 4'b0000);
        step_at(1'b1, 32'h0000_0200, 4'b0000);
        // time running backwards looks like a huge press time
        step_at(1'b0, 32'h0000_0100, 4'b0000);
        step_at(1'b0, 32'h0000_0080, 4'b0000);
        step_at(1'b1, 32'hFFFF_FFFF, 4'b1111);
    endtask

    task automatic test_config_extremes();
        write_timing(16'd0, 16'd0, 16'd0, 16'd0);
        run_gestures(40);
        write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_gestures(40);
        write_timing(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        run_gestures(30);
        write_timing(DebounceRst, GapRst, HoldRst, LongHoldRst);
        run_gestures(30);
    endtask

    task automatic test_output_holdoff();
        settle();
        holdoff_req = 80;
        burst_mode = 1'b1;
        repeat (30) step_line(1'($urandom_range(0, 1)), near(debounce_lim));
        burst_mode = 1'b0;
    endtask

    task automatic test_sender_pause();
        repeat (3)
        begin
            repeat (8) step_line(1'($urandom_range(0, 1)), near(gap_lim));
            settle();
        end
    endtask

    task automatic test_random_gestures();
        for (int seg = 0; seg < 4; seg++)
        begin
            if (seg == 0)
                write_timing(DebounceRst, GapRst, HoldRst, LongHoldRst);
            else if (seg == 3)
                write_timing(CfgW'($urandom), CfgW'($urandom), CfgW'($urandom),
                             CfgW'($urandom));
            else
                write_timing(CfgW'($urandom_range(0, 50)), CfgW'($urandom_range(0, 400)),
                             CfgW'($urandom_range(0, 1500)), CfgW'($urandom_range(0, 4000)));
            line_ms = $urandom;
            run_gestures(210);
        end
    endtask

    initial
    begin
        debounce_lim  = DebounceRst;
        gap_lim       = GapRst;
        hold_lim      = HoldRst;
        long_lim      = LongHoldRst;
        line_was_high = 1'b1;
        pressed_at    = '0;
        released_at   = '0;
        skip_release  = 1'b0;
        click_armed   = 1'b1;
        hold_raised   = 1'b0;
        long_raised   = 1'b0;
        double_armed  = 1'b0;
        gap_open      = 1'b0;
        flags         = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up();
        test_directed_gestures();
        test_config_extremes();
        test_output_holdoff();
        test_sender_pause();
        test_random_gestures();

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("button_click_hold_detector_unit verification clean");
        else
            $display("button_click_hold_detector_unit verification failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/bcd_pkg.sv
rtl/bcd_cfg.sv
rtl/bcd_step.sv
rtl/button_click_hold_detector_unit.sv
test/button_click_hold_detector_unit_tb.sv
